[hdl/rfls_pkg.sv]
// ----------------------------------------------------------------------------
// rfls_pkg
// Shared types and constants for the request frame length scanner: beat
// structs, character codes, op and status codes and parser phase codes.
// ----------------------------------------------------------------------------
package rfls_pkg;

  // Width of a decimal count or length field
  localparam int LEN_BITS = 32;
  // Width of the frame byte counter
  localparam int CNT_BITS = 32;

  // Character codes
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;

  // Input op codes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_ABORT = 1'b1;

  // Result status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  // Parser phase codes
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_CNT    = 4'd1;
  localparam logic [3:0] PH_CNT_LF = 4'd2;
  localparam logic [3:0] PH_BULK   = 4'd3;
  localparam logic [3:0] PH_LEN    = 4'd4;
  localparam logic [3:0] PH_LEN_LF = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_TRL_CR = 4'd7;
  localparam logic [3:0] PH_TRL_LF = 4'd8;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [CNT_BITS-1:0] frame_length;
  } rsp_t;

endpackage

[hdl/rfls_core.sv]
// ----------------------------------------------------------------------------
// rfls_core
// Frame parser state and its per-byte update. One registered byte is taken
// per step; a finished or broken frame raises hit with its result.
// ----------------------------------------------------------------------------
module rfls_core
  import rfls_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t item,
  output logic hit,
  output rsp_t res
);

  logic [3:0]          phase, phase_next;
  logic [LEN_BITS-1:0] number_accum, number_accum_next;
  logic                digit_seen, digit_seen_next;
  logic [LEN_BITS-1:0] elements_left, elements_left_next;
  logic [LEN_BITS-1:0] data_left, data_left_next;
  logic [CNT_BITS-1:0] byte_count, byte_count_next;

  logic [7:0]          b;
  logic                num_char;
  logic [3:0]          digit;
  logic [LEN_BITS+3:0] acc_ext;
  logic [LEN_BITS+3:0] acc_mul;
  logic                acc_ovf;
  logic [CNT_BITS-1:0] bc_inc;
  logic                bc_full;
  logic                fail;
  logic                done;
  logic                clear;

  // Decimal digit step: accum * 10 + digit, with overflow out of LEN_BITS
  assign b        = item.data_byte;
  assign num_char = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);
  assign acc_ext  = {4'b0, number_accum};
  assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + {{LEN_BITS{1'b0}}, digit};
  assign acc_ovf  = |acc_mul[LEN_BITS+3:LEN_BITS];

  assign bc_inc  = byte_count + 1'b1;
  assign bc_full = &byte_count;

  // Decide the next state and any result for this byte
  always_comb begin
    phase_next         = phase;
    number_accum_next  = number_accum;
    digit_seen_next    = digit_seen;
    elements_left_next = elements_left;
    data_left_next     = data_left;
    byte_count_next    = byte_count;
    fail               = 1'b0;
    done               = 1'b0;
    clear              = 1'b0;

    if (item.op == OP_ABORT) begin
      clear = 1'b1;
    end else if (bc_full) begin
      fail = 1'b1;
    end else begin
      byte_count_next = bc_inc;
      unique case (phase)
        PH_IDLE: begin
          if (b != CH_STAR) begin
            fail = 1'b1;
          end else begin
            number_accum_next = '0;
            digit_seen_next   = 1'b0;
            phase_next        = PH_CNT;
          end
        end
        PH_CNT, PH_LEN: begin
          if (b == CH_CR) begin
            if (!digit_seen) begin
              fail = 1'b1;
            end else begin
              phase_next = (phase == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
            end
          end else if (!num_char || acc_ovf) begin
            fail = 1'b1;
          end else begin
            number_accum_next = acc_mul[LEN_BITS-1:0];
            digit_seen_next   = 1'b1;
          end
        end
        PH_CNT_LF: begin
          if (b != CH_LF) begin
            fail = 1'b1;
          end else if (number_accum == '0) begin
            done = 1'b1;
          end else begin
            elements_left_next = number_accum;
            phase_next         = PH_BULK;
          end
        end
        PH_BULK: begin
          if (b != CH_DOLLAR) begin
            fail = 1'b1;
          end else begin
            number_accum_next = '0;
            digit_seen_next   = 1'b0;
            phase_next        = PH_LEN;
          end
        end
        PH_LEN_LF: begin
          if (b != CH_LF) begin
            fail = 1'b1;
          end else begin
            data_left_next = number_accum;
            phase_next     = (number_accum == '0) ? PH_TRL_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          data_left_next = (data_left != '0) ? data_left - 1'b1 : data_left;
          if (data_left_next == '0) begin
            phase_next = PH_TRL_CR;
          end
        end
        PH_TRL_CR: begin
          if (b != CH_CR) begin
            fail = 1'b1;
          end else begin
            phase_next = PH_TRL_LF;
          end
        end
        PH_TRL_LF: begin
          if (b != CH_LF) begin
            fail = 1'b1;
          end else begin
            elements_left_next =
              (elements_left != '0) ? elements_left - 1'b1 : elements_left;
            if (elements_left_next == '0) begin
              done = 1'b1;
            end else begin
              phase_next = PH_BULK;
            end
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end

    // Drop the whole frame on abort or on any result
    if (clear || fail || done) begin
      phase_next         = PH_IDLE;
      number_accum_next  = '0;
      digit_seen_next    = 1'b0;
      elements_left_next = '0;
      data_left_next     = '0;
      byte_count_next    = '0;
    end
  end

  // Result for this byte
  assign hit              = step && (fail || done);
  assign res.status       = fail ? ST_ERROR : ST_DONE;
  assign res.frame_length = fail ? '0 : bc_inc;

  // Advance parser state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      number_accum  <= '0;
      digit_seen    <= 1'b0;
      elements_left <= '0;
      data_left     <= '0;
      byte_count    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      number_accum  <= number_accum_next;
      digit_seen    <= digit_seen_next;
      elements_left <= elements_left_next;
      data_left     <= data_left_next;
      byte_count    <= byte_count_next;
    end
  end

endmodule

[hdl/resp_frame_length_scanner_top.sv]
// Path: the beat closing a frame is held in the input register; its result is
// loaded into the result register once that register is free or being drained.
// Throughput: one byte beat per cycle unless a held result is stalled, set by
// the single parser state update per byte between input and result register.
// Reset: synchronous rst returns the parser to idle with all counts cleared
// and empties both the input and the result register.
// ----------------------------------------------------------------------------
// resp_frame_length_scanner_top
// Scans a request byte stream for '*' count CR LF followed by bulk strings
// and reports each frame's byte length, or an error on malformed framing.
// ----------------------------------------------------------------------------
module resp_frame_length_scanner_top
  import rfls_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  logic s0_valid;
  req_t s0_item;
  logic advance;
  logic step;
  logic hit;
  rsp_t res;

  // Stage moves when the result register is free or being drained
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s0_valid || advance;
  assign step      = s0_valid && advance;

  // Hold the incoming beat in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (req_ready) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s0_item <= req_data;
    end
  end

  rfls_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s0_item),
    .hit  (hit),
    .res  (res)
  );

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      rsp_data <= res;
    end
  end

  // Error results carry no length
  a_err_len_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == ST_ERROR) |-> rsp_data.frame_length == '0)
    else $error("error result with nonzero frame length");

  // Shortest complete frame is '*0' CR LF
  a_done_min_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == ST_DONE) |-> rsp_data.frame_length >= 4)
    else $error("complete frame shorter than four bytes");

  // Empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled while result register empty");

endmodule

[tb/tb_resp_frame_length_scanner_top.sv]
// ----------------------------------------------------------------------------
// tb_resp_frame_length_scanner_top
// Self-checking bench for the request frame length scanner. Byte beats go in
// over a valid/ready channel. A scoreboard runs its own parser on every
// accepted beat, queues the expected result, and checks each result beat
// against it field by field. A short directed burst comes first. Random
// frames follow, mostly well formed with random content and some corrupted,
// truncated, oversize or pure noise. The random frames run under several mixes
// of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_resp_frame_length_scanner_top;
  import rfls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned FRAME_MAX = (64'd1 << CNT_BITS) - 64'd1;
  localparam longint unsigned NUM_MAX   = ((64'd1 << (LEN_BITS - 1)) << 1) - 64'd1;
  localparam longint unsigned DEC_BASE  = 64'd10;
  localparam int HOLD_CYCLES     = 200;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int MAX_REPORTS     = 20;

  // Expected-result tracker: mirrors the frame parser and holds the pending results
  class frame_len_tracker;
    rsp_t            expected_q[$];
    logic [3:0]      phase;
    longint unsigned accum;
    bit              digit_seen;
    longint unsigned elems_left;
    longint unsigned data_left;
    longint unsigned byte_count;
    int              fail_count;
    int              done_count;
    int              error_count;
    int              abort_count;

    function new();
      clear();
    endfunction

    function void clear();
      phase      = PH_IDLE;
      accum      = 0;
      digit_seen = 1'b0;
      elems_left = 0;
      data_left  = 0;
      byte_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Queue one result and return the parser to idle
    function void close_frame(logic st, longint unsigned len);
      rsp_t r;
      r.status       = st;
      r.frame_length = CNT_BITS'(len);
      expected_q.push_back(r);
      if (st == ST_DONE) begin
        done_count++;
      end else begin
        error_count++;
      end
      clear();
    endfunction

    // Advance the parser by one accepted beat
    function void note_byte(req_t b);
      longint unsigned dig;
      if (b.op == OP_ABORT) begin
        abort_count++;
        clear();
        return;
      end
      if (byte_count >= FRAME_MAX) begin
        close_frame(ST_ERROR, 0);
        return;
      end
      byte_count++;
      case (phase)
        PH_IDLE: begin
          if (b.data_byte != CH_STAR) begin
            close_frame(ST_ERROR, 0);
          end else begin
            accum      = 0;
            digit_seen = 1'b0;
            phase      = PH_CNT;
          end
        end
        PH_CNT, PH_LEN: begin
          if (b.data_byte == CH_CR) begin
            if (!digit_seen) begin
              close_frame(ST_ERROR, 0);
            end else begin
              phase = (phase == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
            end
          end else if (b.data_byte < CH_ZERO || b.data_byte > CH_NINE) begin
            close_frame(ST_ERROR, 0);
          end else begin
            dig = 64'(b.data_byte - CH_ZERO);
            // flag the digit that would overflow, never wrap
            if (accum > (NUM_MAX - dig) / DEC_BASE) begin
              close_frame(ST_ERROR, 0);
            end else begin
              accum      = accum * DEC_BASE + dig;
              digit_seen = 1'b1;
            end
          end
        end
        PH_CNT_LF: begin
          if (b.data_byte != CH_LF) begin
            close_frame(ST_ERROR, 0);
          end else begin
            elems_left = accum;
            if (elems_left == 0) begin
              close_frame(ST_DONE, byte_count);
            end else begin
              phase = PH_BULK;
            end
          end
        end
        PH_BULK: begin
          if (b.data_byte != CH_DOLLAR) begin
            close_frame(ST_ERROR, 0);
          end else begin
            accum      = 0;
            digit_seen = 1'b0;
            phase      = PH_LEN;
          end
        end
        PH_LEN_LF: begin
          if (b.data_byte != CH_LF) begin
            close_frame(ST_ERROR, 0);
          end else begin
            data_left = accum;
            phase     = (data_left == 0) ? PH_TRL_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_left > 0) data_left--;
          if (data_left == 0) phase = PH_TRL_CR;
        end
        PH_TRL_CR: begin
          if (b.data_byte != CH_CR) begin
            close_frame(ST_ERROR, 0);
          end else begin
            phase = PH_TRL_LF;
          end
        end
        PH_TRL_LF: begin
          if (b.data_byte != CH_LF) begin
            close_frame(ST_ERROR, 0);
          end else begin
            if (elems_left > 0) elems_left--;
            if (elems_left == 0) begin
              close_frame(ST_DONE, byte_count);
            end else begin
              phase = PH_BULK;
            end
          end
        end
        default: close_frame(ST_ERROR, 0);
      endcase
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, status %0d length %0d",
                   $time, got.status, got.frame_length);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, got.status);
      end
      if (got.frame_length !== want.frame_length) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: frame_length mismatch, expected %0d actual %0d",
                   $time, want.frame_length, got.frame_length);
      end
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  frame_len_tracker sb = new();

  req_t frame_q[$];
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_trigger   = 0;
  int   hold_seen      = 0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;
  int   bytes_sent     = 0;
  int   idle_mix[4]    = '{0, 86, 0, 37};
  int   stall_mix[4]   = '{0, 0, 86, 37};

  resp_frame_length_scanner_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: check accepted results, then stall at random or hold off on request
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp_data);
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one beat after a random idle gap and hold it until accepted
  task automatic send_beat(req_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= b;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_queue();
    foreach (frame_q[i]) send_beat(frame_q[i]);
    frame_q.delete();
  endtask

  // Stop offering beats until every expected result has come back
  task automatic pause_for_results();
    req_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic push_byte(logic [7:0] b);
    req_t r;
    r.op        = OP_DATA;
    r.data_byte = b;
    frame_q.push_back(r);
  endtask

  task automatic push_abort();
    req_t r;
    r.op        = OP_ABORT;
    r.data_byte = 8'($urandom_range(255));
    frame_q.push_back(r);
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  // Append a decimal number, optionally with leading zeros
  task automatic push_number(longint unsigned v, int zeros);
    string s;
    s = $sformatf("%0d", v);
    repeat (zeros) push_byte(CH_ZERO);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_edge_byte();
    case ($urandom_range(11))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_STAR;
      3:       return CH_DOLLAR;
      4:       return CH_ZERO;
      5:       return CH_NINE;
      6:       return CH_ZERO - 8'd1;
      7:       return CH_NINE + 8'd1;
      8:       return 8'h00;
      9:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int rand_zeros();
    return ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  // Append a well-formed frame with random counts, lengths and payload
  task automatic push_frame();
    int n_elems;
    int n_data;
    n_elems = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
    push_byte(CH_STAR);
    push_number(n_elems, rand_zeros());
    push_crlf();
    repeat (n_elems) begin
      n_data = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
      push_byte(CH_DOLLAR);
      push_number(n_data, rand_zeros());
      push_crlf();
      repeat (n_data) push_byte(8'($urandom_range(255)));
      push_crlf();
    end
  endtask

  // Build one random frame: mostly clean, the rest broken in various ways
  task automatic build_frame();
    int kind;
    int idx;
    kind = $urandom_range(99);
    if (kind < 65) begin
      push_frame();
    end else if (kind < 80) begin
      // corrupt one byte of a clean frame
      push_frame();
      idx = $urandom_range(frame_q.size() - 1);
      frame_q[idx].data_byte = pick_edge_byte();
    end else if (kind < 87) begin
      // cut the frame short and abort it
      push_frame();
      idx = $urandom_range(frame_q.size() - 1);
      frame_q = frame_q[0:idx];
      push_abort();
    end else if (kind < 92) begin
      // noise beats, some of them aborts
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(4) == 0) push_abort();
        else push_byte(pick_edge_byte());
      end
    end else begin
      push_byte(CH_STAR);
      case ($urandom_range(3))
        0: begin
          // count just past the limit
          push_number(NUM_MAX + 64'($urandom_range(1, 100000)), 0);
          push_crlf();
        end
        1: begin
          // count with many digits
          push_number(NUM_MAX + 64'd1 + 64'($urandom) * 64'd7, rand_zeros());
        end
        2: begin
          // largest legal count, then drop the frame
          push_number(NUM_MAX, rand_zeros());
          push_crlf();
          push_byte(CH_DOLLAR);
          push_number(1, 0);
          push_crlf();
          push_byte(8'($urandom_range(255)));
          push_crlf();
          push_abort();
        end
        default: begin
          // bulk length at or past the limit
          push_number(1, 0);
          push_crlf();
          push_byte(CH_DOLLAR);
          push_number(NUM_MAX + 64'($urandom_range(1)), 0);
          push_crlf();
          repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(255)));
          push_abort();
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] junk;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes, empty array, zero-length bulk, abort, empty count
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CH_STAR);
    push_number(0, 0);
    push_crlf();
    push_byte(CH_STAR);
    push_number(1, 0);
    push_crlf();
    push_byte(CH_DOLLAR);
    push_number(0, 0);
    push_crlf();
    push_crlf();
    push_byte(CH_STAR);
    push_abort();
    push_byte(CH_STAR);
    push_byte(CH_CR);
    send_queue();
    pause_for_results();

    // Hold off the receiver while junk keeps coming so the block backs up
    hold_trigger++;
    repeat (40) begin
      junk = 8'($urandom_range(255));
      if (junk == CH_STAR) junk = 8'h00;
      push_byte(junk);
    end
    send_queue();
    pause_for_results();

    // Random frames under each idle/stall mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      bytes_sent     = 0;
      while (bytes_sent < ITEMS_PER_PHASE) begin
        build_frame();
        send_queue();
      end
      pause_for_results();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d complete frames, %0d error results and %0d aborts",
             sb.done_count, sb.error_count, sb.abort_count);
    $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
    if (sb.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
